@@ rtl/core/mrts_pkg.sv @@
// shared types and codes of the min-runtime task scheduler
package mrts_pkg;

  // width of a process runtime and of the slice length
  localparam int RT_W    = 48;
  localparam int SLICE_W = 20;
  localparam logic [RT_W-1:0] RT_MAX = {RT_W{1'b1}};

  // process state codes
  typedef enum logic [2:0] {
    ST_UNUSED       = 3'd0,
    ST_SLEEPING     = 3'd1,
    ST_DEEPSLEEPING = 3'd2,
    ST_RUNNABLE     = 3'd3,
    ST_RUNNING      = 3'd4,
    ST_ZOMBIE       = 3'd5
  } proc_state_e;

  // operation codes
  typedef enum logic [1:0] {
    FN_ACTIVATE = 2'd0,
    FN_SCHEDULE = 2'd1,
    FN_EXPIRE   = 2'd2,
    FN_KILL     = 2'd3
  } func_e;

  // one request
  typedef struct packed {
    func_e       func;
    logic [1:0]  cpu;
    logic [3:0]  pid;
    logic        onalert;
    logic [2:0]  set_state;
  } in_item_t;

  // one result
  typedef struct packed {
    logic        accepted;
    logic [3:0]  next_pid;
    logic        switched;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_LOOKUP,
    CS_MODIFY,
    CS_SCAN,
    CS_SCAN_TAIL,
    CS_RD_BEST,
    CS_WR_BEST,
    CS_FINISH
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic lookup;
    logic modify;
    logic scan_start;
    logic scan_step;
    logic rd_best;
    logic commit;
    logic emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic target_ok;
    logic pick;
    logic scan_last;
  } dp_status_t;

endpackage

@@ rtl/core/mrts_ctrl.sv @@
// sequencing state machine of the min-runtime task scheduler
module mrts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  mrts_pkg::dp_status_t status_i,
  output mrts_pkg::dp_cmd_t    cmd_o
);

  mrts_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  // result register can take a new transaction
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mrts_pkg::CS_IDLE: begin
        if (in_valid_i) state_d = mrts_pkg::CS_LOOKUP;
      end
      mrts_pkg::CS_LOOKUP: begin
        state_d = status_i.target_ok ? mrts_pkg::CS_MODIFY : mrts_pkg::CS_FINISH;
      end
      mrts_pkg::CS_MODIFY: begin
        state_d = status_i.pick ? mrts_pkg::CS_SCAN : mrts_pkg::CS_FINISH;
      end
      mrts_pkg::CS_SCAN: begin
        if (status_i.scan_last) state_d = mrts_pkg::CS_SCAN_TAIL;
      end
      mrts_pkg::CS_SCAN_TAIL: state_d = mrts_pkg::CS_RD_BEST;
      mrts_pkg::CS_RD_BEST:   state_d = mrts_pkg::CS_WR_BEST;
      mrts_pkg::CS_WR_BEST:   state_d = mrts_pkg::CS_FINISH;
      mrts_pkg::CS_FINISH: begin
        if (out_free) state_d = mrts_pkg::CS_IDLE;
      end
      default: state_d = mrts_pkg::CS_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == mrts_pkg::CS_IDLE) && in_valid_i;
    cmd_o.lookup     = (state_q == mrts_pkg::CS_LOOKUP);
    cmd_o.modify     = (state_q == mrts_pkg::CS_MODIFY);
    cmd_o.scan_start = (state_q == mrts_pkg::CS_MODIFY);
    cmd_o.scan_step  = (state_q == mrts_pkg::CS_SCAN);
    cmd_o.rd_best    = (state_q == mrts_pkg::CS_RD_BEST);
    cmd_o.commit     = (state_q == mrts_pkg::CS_WR_BEST);
    cmd_o.emit       = (state_q == mrts_pkg::CS_FINISH) && out_free;
  end

  // output valid flag
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrts_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != mrts_pkg::CS_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/mrts_dp.sv @@
// process table, run-queue scan and result registers of the scheduler
module mrts_dp #(
  parameter int NUM_CPUS  = 4,
  parameter int NUM_PROCS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mrts_pkg::dp_cmd_t             cmd_i,
  output mrts_pkg::dp_status_t          status_o,
  input  mrts_pkg::in_item_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [mrts_pkg::SLICE_W-1:0]  cfg_slice_len_i,
  output mrts_pkg::out_item_t           out_item_o
);

  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int RW = mrts_pkg::RT_W;
  localparam logic [PW-1:0] LAST = PW'(NUM_PROCS - 1);

  // process table, one row per slot
  logic [2:0]    st_mem [NUM_PROCS];
  logic [RW-1:0] rt_mem [NUM_PROCS];
  logic          kl_mem [NUM_PROCS];
  logic [CW-1:0] qu_mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] row_vld_q;

  // registered read port
  logic [2:0]    rd_st_q;
  logic [RW-1:0] rd_rt_q;
  logic          rd_kl_q;
  logic [CW-1:0] rd_qu_q;
  logic          rd_vld_q;
  logic [PW-1:0] rd_addr_q;

  // item and working registers
  mrts_pkg::in_item_t           item_q;
  logic [mrts_pkg::SLICE_W-1:0] slice_q;
  logic [PW-1:0]                rpid_q [NUM_CPUS];
  logic [PW-1:0]                tgt_q;
  logic [PW-1:0]                cnt_q;
  logic [PW-1:0]                best_q;
  logic [RW-1:0]                best_rt_q;
  logic                         found_q;
  logic                         eval_q;
  logic                         res_acc_q;
  logic [3:0]                   res_nxt_q;
  logic                         res_sw_q;
  mrts_pkg::out_item_t          out_q;

  // decoded item
  logic [PW-1:0] pid_idx, c_p, cur, item_addr;
  logic [CW-1:0] c_c, pmod;
  logic          pid_ok, cok, is_sched, target_ok;

  // row view and update
  logic [2:0]    v_st, m_st, ns;
  logic [RW-1:0] v_rt, m_rt, rt_chg;
  logic [RW:0]   rt_sum;
  logic          v_kl, m_kl;
  logic [CW-1:0] v_qu, m_qu;
  logic          tgt_idle, ns_ok, refused, wake, mod_acc, cand;

  // memory port control
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [2:0]    wr_st;
  logic [RW-1:0] wr_rt;
  logic          wr_kl;
  logic [CW-1:0] wr_qu;

  // item decode
  assign pid_idx   = PW'(item_q.pid);
  assign c_p       = PW'(item_q.cpu);
  assign c_c       = CW'(item_q.cpu);
  assign pid_ok    = 32'(item_q.pid) < NUM_PROCS;
  assign cok       = (32'(item_q.cpu) < NUM_CPUS) && (32'(item_q.cpu) < NUM_PROCS);
  assign cur       = cok ? rpid_q[c_c] : '0;
  assign is_sched  = (item_q.func == mrts_pkg::FN_SCHEDULE) ||
                     (item_q.func == mrts_pkg::FN_EXPIRE);
  assign target_ok = is_sched ? cok : pid_ok;
  assign item_addr = is_sched ? cur : pid_idx;

  // home cpu of the pid, small constant table
  always_comb begin
    pmod = '0;
    for (int i = 0; i < 16; i++) begin
      if (item_q.pid == 4'(i)) pmod = CW'(i % NUM_CPUS);
    end
  end

  // read view, rows never written show their reset contents
  always_comb begin
    if (rd_vld_q) begin
      v_st = rd_st_q;
      v_rt = rd_rt_q;
      v_kl = rd_kl_q;
      v_qu = rd_qu_q;
    end else begin
      v_st = (32'(rd_addr_q) < NUM_CPUS) ? mrts_pkg::ST_RUNNING : mrts_pkg::ST_UNUSED;
      v_rt = '0;
      v_kl = 1'b0;
      v_qu = '0;
    end
  end

  // checks on the target row
  assign tgt_idle = 32'(tgt_q) < NUM_CPUS;
  assign ns       = (item_q.func == mrts_pkg::FN_EXPIRE) ? mrts_pkg::ST_RUNNABLE
                                                         : item_q.set_state;
  assign ns_ok    = ns inside {mrts_pkg::ST_UNUSED, mrts_pkg::ST_SLEEPING,
                               mrts_pkg::ST_DEEPSLEEPING, mrts_pkg::ST_RUNNABLE,
                               mrts_pkg::ST_ZOMBIE};
  assign refused  = (v_kl && (ns != mrts_pkg::ST_ZOMBIE)) || !ns_ok;
  assign wake     = (v_st inside {mrts_pkg::ST_UNUSED, mrts_pkg::ST_SLEEPING,
                                  mrts_pkg::ST_DEEPSLEEPING}) &&
                    !(item_q.onalert && (v_st == mrts_pkg::ST_DEEPSLEEPING));

  // saturating runtime charge
  assign rt_sum = {1'b0, v_rt} + (RW+1)'(slice_q);
  assign rt_chg = (item_q.func == mrts_pkg::FN_EXPIRE)
                  ? (rt_sum[RW] ? mrts_pkg::RT_MAX : rt_sum[RW-1:0]) : v_rt;

  // updated target row
  always_comb begin
    m_st    = v_st;
    m_rt    = v_rt;
    m_kl    = v_kl;
    m_qu    = v_qu;
    mod_acc = 1'b0;
    case (item_q.func)
      mrts_pkg::FN_ACTIVATE: begin
        mod_acc = wake;
        if (wake) begin
          m_st = mrts_pkg::ST_RUNNABLE;
          if (!tgt_idle) m_qu = pmod;
        end
      end
      mrts_pkg::FN_KILL: begin
        m_kl    = 1'b1;
        mod_acc = 1'b1;
      end
      default: begin
        m_rt    = rt_chg;
        mod_acc = !refused;
        if (!refused) begin
          m_st = ns;
          if ((ns == mrts_pkg::ST_RUNNABLE) && !tgt_idle) m_qu = c_c;
        end
      end
    endcase
  end

  // scan candidate, strict less keeps the lower pid on ties
  assign cand = eval_q && !(32'(rd_addr_q) < NUM_CPUS) &&
                (v_st == mrts_pkg::ST_RUNNABLE) && (v_qu == c_c) &&
                (!found_q || (v_rt < best_rt_q));

  // memory port control
  assign rd_en   = (cmd_i.lookup && target_ok) || cmd_i.scan_step || cmd_i.rd_best;
  assign rd_addr = cmd_i.lookup ? item_addr : (cmd_i.scan_step ? cnt_q : best_q);
  assign wr_en   = cmd_i.modify || cmd_i.commit;
  assign wr_addr = cmd_i.modify ? tgt_q : best_q;
  assign wr_st   = cmd_i.modify ? m_st : mrts_pkg::ST_RUNNING;
  assign wr_rt   = cmd_i.modify ? m_rt : v_rt;
  assign wr_kl   = cmd_i.modify ? m_kl : v_kl;
  assign wr_qu   = cmd_i.modify ? m_qu : v_qu;

  // process table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      st_mem[wr_addr] <= wr_st;
      rt_mem[wr_addr] <= wr_rt;
      kl_mem[wr_addr] <= wr_kl;
      qu_mem[wr_addr] <= wr_qu;
    end
    if (rd_en) begin
      rd_st_q   <= st_mem[rd_addr];
      rd_rt_q   <= rt_mem[rd_addr];
      rd_kl_q   <= kl_mem[rd_addr];
      rd_qu_q   <= qu_mem[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // control state: config, running pids, row valid bits, scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q   <= mrts_pkg::SLICE_W'(1);
      row_vld_q <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      eval_q    <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        rpid_q[i] <= (i < NUM_PROCS) ? PW'(i) : '0;
      end
    end else begin
      if (cfg_we_i) slice_q <= cfg_slice_len_i;
      if (wr_en) row_vld_q[wr_addr] <= 1'b1;
      eval_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) cnt_q <= cnt_q + 1'b1;
        if (cand) found_q <= 1'b1;
      end
      if (cmd_i.commit) rpid_q[c_c] <= best_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.lookup) begin
      tgt_q     <= item_addr;
      res_acc_q <= 1'b0;
      res_nxt_q <= cok ? 4'(cur) : 4'd0;
      res_sw_q  <= 1'b0;
    end
    if (cmd_i.modify) res_acc_q <= mod_acc;
    if (cmd_i.scan_start) begin
      best_q <= c_p;
    end else if (cand) begin
      best_q    <= rd_addr_q;
      best_rt_q <= v_rt;
    end
    if (cmd_i.commit) begin
      res_acc_q <= 1'b1;
      res_nxt_q <= 4'(best_q);
      res_sw_q  <= (best_q != tgt_q);
    end
    if (cmd_i.emit) begin
      out_q.accepted <= res_acc_q;
      out_q.next_pid <= res_nxt_q;
      out_q.switched <= res_sw_q;
    end
  end

  assign status_o.target_ok = target_ok;
  assign status_o.pick      = is_sched && !refused;
  assign status_o.scan_last = (cnt_q == LAST);
  assign out_item_o         = out_q;

endmodule

@@ rtl/core/min_runtime_task_scheduler_unit.sv @@
// top level of the min-runtime task scheduler
// Per-CPU minimum-runtime scheduler over a table of NUM_PROCS process slots;
// slots below NUM_CPUS are the idle processes. One request is worked at a time
// and gives one result. Activate and kill take a read and a write of the
// target row. Schedule and slice expiry update the current process and, if
// its new state is accepted, scan the whole table one slot per cycle for the
// runnable process of that cpu with the least runtime (lower pid on ties).
// The result sits in an output register, so a new request is taken while the
// previous result is still stalled. The slice length is written through the
// configuration channel, which is always ready; the user must write it only
// while no request is in flight, as the block itself does not enforce it.
module min_runtime_task_scheduler_unit #(
  parameter int NUM_CPUS  = 4,
  parameter int NUM_PROCS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mrts_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrts_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mrts_pkg::SLICE_W-1:0]  cfg_slice_len_i
);

  mrts_pkg::dp_cmd_t    cmd;
  mrts_pkg::dp_status_t status;
  logic                 cfg_we;

  // config register write
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer
  mrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // process table and scan datapath
  mrts_dp #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PROCS (NUM_PROCS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_item_i       (in_item_i),
    .cfg_we_i        (cfg_we),
    .cfg_slice_len_i (cfg_slice_len_i),
    .out_item_o      (out_item_o)
  );

`ifndef SYNTH
  // a taken transaction makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken but block not busy");

  // the running-process write always follows the read of the picked row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> $past(cmd.rd_best))
    else $error("commit without read of picked row");

  // the scan stops after the last slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_step && status.scan_last |=> !cmd.scan_step)
    else $error("scan ran past the last slot");

  // a switch only comes from a schedule that was carried out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.switched |-> out_item_o.accepted)
    else $error("switch reported on a refused request");
`endif

endmodule

@@ verif/min_runtime_task_scheduler_unit_test.sv @@
// self-checking testbench of the min-runtime task scheduler unit
module min_runtime_task_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CPUS   = 4;
  localparam int NUM_PROCS  = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 40;

  // per-cpu run-queue predictor with a queue of expected results
  class sched_scoreboard;
    mrts_pkg::proc_state_e        pstate   [NUM_PROCS];
    logic [mrts_pkg::RT_W-1:0]    rtime    [NUM_PROCS];
    bit                           killed   [NUM_PROCS];
    logic [1:0]                   home_cpu [NUM_PROCS];
    logic [3:0]                   cur_pid  [NUM_CPUS];
    logic [mrts_pkg::SLICE_W-1:0] slice;
    mrts_pkg::out_item_t          result_q [$];
    int                           errors;

    function new();
      for (int i = 0; i < NUM_PROCS; i++) begin
        if (i < NUM_CPUS) begin
          pstate[i] = mrts_pkg::ST_RUNNING;
        end else begin
          pstate[i] = mrts_pkg::ST_UNUSED;
        end
        rtime[i]    = '0;
        killed[i]   = 1'b0;
        home_cpu[i] = '0;
      end
      for (int c = 0; c < NUM_CPUS; c++) begin
        cur_pid[c] = 4'(c);
      end
      slice  = mrts_pkg::SLICE_W'(1);
      errors = 0;
    endfunction

    // queued process of a cpu with the least runtime, lower pid on ties
    function int least_runtime(int c);
      int  best;
      bit  found;
      best  = c;
      found = 1'b0;
      for (int q = NUM_CPUS; q < NUM_PROCS; q++) begin
        if (pstate[q] == mrts_pkg::ST_RUNNABLE && home_cpu[q] == c &&
            (!found || rtime[q] < rtime[best])) begin
          best  = q;
          found = 1'b1;
        end
      end
      return best;
    endfunction

    // give the current process its new state and pick the next one
    function mrts_pkg::out_item_t switch_cpu(int c, logic [2:0] ns);
      logic [3:0]          cur;
      int                  nxt;
      mrts_pkg::out_item_t r;
      cur        = cur_pid[c];
      r.accepted = 1'b0;
      r.next_pid = cur;
      r.switched = 1'b0;
      // killed process refuses anything but zombie
      if (killed[cur] && ns != mrts_pkg::ST_ZOMBIE) return r;
      // running and undefined codes are refused
      if (ns == mrts_pkg::ST_RUNNING || ns > mrts_pkg::ST_ZOMBIE) return r;
      if (ns == mrts_pkg::ST_RUNNABLE && cur >= NUM_CPUS) home_cpu[cur] = 2'(c);
      pstate[cur] = mrts_pkg::proc_state_e'(ns);
      nxt         = least_runtime(c);
      cur_pid[c]  = 4'(nxt);
      pstate[nxt] = mrts_pkg::ST_RUNNING;
      r.accepted  = 1'b1;
      r.next_pid  = 4'(nxt);
      r.switched  = (4'(nxt) != cur);
      return r;
    endfunction

    function mrts_pkg::out_item_t predict(mrts_pkg::in_item_t it);
      mrts_pkg::out_item_t     r;
      mrts_pkg::proc_state_e   s;
      logic [mrts_pkg::RT_W:0] sum;
      logic [3:0]              cur;
      r = '0;
      case (it.func)
        mrts_pkg::FN_ACTIVATE: begin
          s = pstate[it.pid];
          // deep sleepers stay asleep on alert
          if (s == mrts_pkg::ST_SLEEPING || s == mrts_pkg::ST_UNUSED ||
              (s == mrts_pkg::ST_DEEPSLEEPING && !it.onalert)) begin
            pstate[it.pid] = mrts_pkg::ST_RUNNABLE;
            if (it.pid >= NUM_CPUS) home_cpu[it.pid] = it.pid[1:0];
            r.accepted = 1'b1;
          end
          r.next_pid = cur_pid[it.cpu];
        end
        mrts_pkg::FN_KILL: begin
          killed[it.pid] = 1'b1;
          r.accepted     = 1'b1;
          r.next_pid     = cur_pid[it.cpu];
        end
        mrts_pkg::FN_EXPIRE: begin
          // charge the slice, saturating, even if the schedule is refused
          cur = cur_pid[it.cpu];
          sum = {1'b0, rtime[cur]} + (mrts_pkg::RT_W+1)'(slice);
          if (sum[mrts_pkg::RT_W]) begin
            rtime[cur] = mrts_pkg::RT_MAX;
          end else begin
            rtime[cur] = sum[mrts_pkg::RT_W-1:0];
          end
          r = switch_cpu(it.cpu, mrts_pkg::ST_RUNNABLE);
        end
        default: begin
          r = switch_cpu(it.cpu, it.set_state);
        end
      endcase
      return r;
    endfunction

    function void note_input(mrts_pkg::in_item_t it);
      result_q.push_back(predict(it));
    endfunction

    function void check_result(mrts_pkg::out_item_t got);
      mrts_pkg::out_item_t want;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = result_q.pop_front();
      if (got.accepted !== want.accepted) begin
        errors++;
        $display("%0t: accepted mismatch, expected %0b actual %0b",
                 $time, want.accepted, got.accepted);
      end
      if (got.next_pid !== want.next_pid) begin
        errors++;
        $display("%0t: next_pid mismatch, expected %0d actual %0d",
                 $time, want.next_pid, got.next_pid);
      end
      if (got.switched !== want.switched) begin
        errors++;
        $display("%0t: switched mismatch, expected %0b actual %0b",
                 $time, want.switched, got.switched);
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  mrts_pkg::in_item_t           in_item_i       = '0;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;
  mrts_pkg::out_item_t          out_item_o;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [mrts_pkg::SLICE_W-1:0] cfg_slice_len_i = '0;

  sched_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  min_runtime_task_scheduler_unit #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PROCS (NUM_PROCS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_o      (out_item_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_slice_len_i (cfg_slice_len_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // random receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // observe every transaction on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic mrts_pkg::in_item_t req(mrts_pkg::func_e f, int c, int p, bit a,
                                             int ns);
    mrts_pkg::in_item_t it;
    it.func      = f;
    it.cpu       = 2'(c);
    it.pid       = 4'(p);
    it.onalert   = a;
    it.set_state = 3'(ns);
    return it;
  endfunction

  // mostly scheduling traffic with rare kills and zombies
  function automatic mrts_pkg::in_item_t random_request();
    mrts_pkg::in_item_t it;
    int                 r;
    int                 w;
    it.cpu       = 2'($urandom_range(3));
    it.onalert   = 1'($urandom_range(1));
    it.set_state = 3'($urandom_range(7));
    if ($urandom_range(99) < 85) begin
      it.pid = 4'($urandom_range(NUM_PROCS-1, NUM_CPUS));
    end else begin
      it.pid = 4'($urandom_range(NUM_CPUS-1));
    end
    r = $urandom_range(99);
    if (r < 38) begin
      it.func = mrts_pkg::FN_ACTIVATE;
    end else if (r < 68) begin
      it.func = mrts_pkg::FN_SCHEDULE;
      w = $urandom_range(99);
      if (w < 35)      it.set_state = mrts_pkg::ST_RUNNABLE;
      else if (w < 60) it.set_state = mrts_pkg::ST_SLEEPING;
      else if (w < 80) it.set_state = mrts_pkg::ST_DEEPSLEEPING;
      else if (w < 88) it.set_state = mrts_pkg::ST_UNUSED;
      else if (w < 91) it.set_state = mrts_pkg::ST_ZOMBIE;
      else if (w < 94) it.set_state = mrts_pkg::ST_RUNNING;
      else             it.set_state = 3'($urandom_range(7, 6));
    end else if (r < 99) begin
      it.func = mrts_pkg::FN_EXPIRE;
    end else begin
      it.func = mrts_pkg::FN_KILL;
    end
    return it;
  endfunction

  // one request transaction, entered and left at a falling edge
  task automatic send_request(input mrts_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // hold off until every expected result is back and the unit is quiet
  task automatic drain_results(input int settle);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_slice(input logic [mrts_pkg::SLICE_W-1:0] v);
    cfg_valid_i     = 1'b1;
    cfg_slice_len_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.slice = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  initial begin
    mrts_pkg::in_item_t plan [$];

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: wakeups, ties, refusals, kill and zombie exit
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 0, 4, 0, 0));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 0, 4, 1, 7));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 1, 8, 0, 0));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 0, mrts_pkg::ST_RUNNABLE));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 0, 0, 1, 0));
    plan.push_back(req(mrts_pkg::FN_EXPIRE,   0, 0, 0, 0));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 0, mrts_pkg::ST_DEEPSLEEPING));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 2, 8, 1, 0));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 2, 8, 0, 0));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 0, mrts_pkg::ST_SLEEPING));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 0, mrts_pkg::ST_RUNNING));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 1, 6));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 15, 1, 7));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 0, mrts_pkg::ST_UNUSED));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 0, 0, 0, mrts_pkg::ST_RUNNABLE));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 3, 15, 0, 0));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 3, 0, 0, mrts_pkg::ST_RUNNABLE));
    plan.push_back(req(mrts_pkg::FN_KILL,     3, 15, 1, 7));
    plan.push_back(req(mrts_pkg::FN_EXPIRE,   3, 0, 0, 0));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 3, 0, 0, mrts_pkg::ST_SLEEPING));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 3, 0, 0, mrts_pkg::ST_ZOMBIE));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 3, 15, 0, 0));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 1, 1, 1, 0));
    plan.push_back(req(mrts_pkg::FN_SCHEDULE, 1, 0, 0, mrts_pkg::ST_SLEEPING));
    plan.push_back(req(mrts_pkg::FN_ACTIVATE, 2, 6, 0, 0));
    plan.push_back(req(mrts_pkg::FN_EXPIRE,   2, 0, 1, 7));
    foreach (plan[i]) send_request(plan[i]);
    drain_results(SETTLE);

    // largest slice, slow sender against a slower receiver
    write_slice({mrts_pkg::SLICE_W{1'b1}});
    send_idle_pct  = 32;
    recv_stall_pct = 66;
    run_random(100);
    // sender waits for every outstanding result
    drain_results(0);
    run_random(100);
    drain_results(SETTLE);

    // random slice, roles swapped
    write_slice(mrts_pkg::SLICE_W'($urandom_range((1 << mrts_pkg::SLICE_W) - 2, 2)));
    send_idle_pct  = 66;
    recv_stall_pct = 32;
    run_random(200);
    drain_results(SETTLE);

    // slice of one, back to back
    write_slice(mrts_pkg::SLICE_W'(1));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(200);
    drain_results(SETTLE);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mrts_pkg.sv
rtl/core/mrts_ctrl.sv
rtl/core/mrts_dp.sv
rtl/core/min_runtime_task_scheduler_unit.sv
verif/min_runtime_task_scheduler_unit_test.sv
